>>> src/nart_pkg.sv
// Shared constants for the axis-reversal transpose address generator.
// No dependencies; imported by every module of the block except nart_queue.
`default_nettype none

package nart_pkg;

    // Default sizing, handed down from the top level as parameters
    localparam int MAX_DIMS_DEF    = 4;
    localparam int EXTENT_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF  = 32;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Element payload
    localparam int DATA_BITS   = 64;
    localparam int NARROW_BITS = 32;

    // Element kind codes (code 3 is unknown and passes all bits)
    localparam logic [1:0] KIND_INT32   = 2'd0;
    localparam logic [1:0] KIND_FLOAT32 = 2'd1;
    localparam logic [1:0] KIND_FLOAT64 = 2'd2;

    // Register indexes: dimension count, then one extent per axis, then kind
    localparam int CFG_IDX_NUM_DIMS = 0;
    localparam int CFG_IDX_DIM_BASE = 1;

endpackage

`default_nettype wire

>>> src/nart_front.sv
// Front end: mixed-radix source index counter, last-element detect and payload masking.
// Depends on nart_pkg; writes one entry per accepted request into nart_queue.
`default_nettype none

module nart_front import nart_pkg::*; #(
    parameter int MAX_DIMS    = MAX_DIMS_DEF,
    parameter int EXTENT_BITS = EXTENT_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_accept,
    input  wire logic [DATA_BITS-1:0]                   i_element_bits,
    input  wire logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]   i_ext,
    input  wire logic [MAX_DIMS-1:0]                    i_use,
    input  wire logic                                   i_narrow,
    output logic      [MAX_DIMS-1:0][EXTENT_BITS-1:0]   o_digits,
    output logic      [DATA_BITS-1:0]                   o_data,
    output logic                                        o_last
);

    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] r_cnt;
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] n_cnt;
    logic [MAX_DIMS-1:0]                  w_top;
    logic [MAX_DIMS:0]                    w_cy;
    logic                                 w_in_use_zero;

    // Digit at or above extent minus one counts as top; stale digits wrap too
    always_comb begin
        for (int k = 0; k < MAX_DIMS; k++) begin
            w_top[k] = (r_cnt[k] >= (i_ext[k] - EXTENT_BITS'(1)));
        end
    end

    // Carry ripples from the fastest axis towards axis 0; unused axes pass it on
    always_comb begin
        w_cy[MAX_DIMS] = 1'b1;
        n_cnt          = r_cnt;
        for (int k = MAX_DIMS - 1; k >= 0; k--) begin
            if (i_use[k]) begin
                w_cy[k] = w_cy[k+1] & w_top[k];
                if (w_cy[k+1]) begin
                    n_cnt[k] = w_top[k] ? '0 : r_cnt[k] + EXTENT_BITS'(1);
                end
            end else begin
                w_cy[k] = w_cy[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
        end
    end

    // Entry for the queue: indices of this element, masked payload, end flag
    assign o_digits = r_cnt;
    assign o_last   = w_cy[0];
    assign o_data   = i_narrow ?
                      {{(DATA_BITS-NARROW_BITS){1'b0}}, i_element_bits[NARROW_BITS-1:0]} :
                      i_element_bits;

    always_comb begin
        w_in_use_zero = 1'b1;
        for (int k = 0; k < MAX_DIMS; k++) begin
            if (i_use[k] && (r_cnt[k] != '0)) begin
                w_in_use_zero = 1'b0;
            end
        end
    end

    // The counter is back at the array origin after the final element
    a_wrap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_last |=> w_in_use_zero)
        else $error("counter did not wrap after last element");

endmodule

`default_nettype wire

>>> src/nart_queue.sv
// Short register queue between front and back.
// Generic width and depth; no package dependency.
`default_nettype none

module nart_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_rd,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full && !i_rd))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && o_empty))
        else $error("queue read while empty");

endmodule

`default_nettype wire

>>> src/nart_size.sv
// Running product of the extents in use, one axis per stage, with an overflow flag.
// Depends on nart_pkg; feeds the size error flag to nart_back.
`default_nettype none

module nart_size import nart_pkg::*; #(
    parameter int MAX_DIMS    = MAX_DIMS_DEF,
    parameter int EXTENT_BITS = EXTENT_BITS_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] i_ext,
    input  wire logic [MAX_DIMS-1:0]                  i_use,
    output logic                                      o_size_err
);

    localparam int PB = INDEX_BITS + 1;
    localparam int QB = PB + EXTENT_BITS;
    localparam logic [QB-1:0] LIMIT = QB'(1) << INDEX_BITS;

    logic [PB-1:0] r_prod [MAX_DIMS];
    logic          r_ovf  [MAX_DIMS];
    logic [PB-1:0] n_prod [MAX_DIMS];
    logic          n_ovf  [MAX_DIMS];
    logic [PB-1:0] w_pin  [MAX_DIMS];
    logic          w_oin  [MAX_DIMS];
    logic [QB-1:0] w_q    [MAX_DIMS];

    // Stage k multiplies in extent k while no overflow has been seen
    always_comb begin
        for (int k = 0; k < MAX_DIMS; k++) begin
            w_pin[k]  = (k == 0) ? PB'(1) : r_prod[(k == 0) ? 0 : k - 1];
            w_oin[k]  = (k == 0) ? 1'b0 : r_ovf[(k == 0) ? 0 : k - 1];
            w_q[k]    = {{EXTENT_BITS{1'b0}}, w_pin[k]} * {{PB{1'b0}}, i_ext[k]};
            n_prod[k] = w_pin[k];
            n_ovf[k]  = w_oin[k];
            if (i_use[k] && !w_oin[k]) begin
                if (w_q[k] > LIMIT) begin
                    n_ovf[k] = 1'b1;
                end else begin
                    n_prod[k] = w_q[k][PB-1:0];
                end
            end
        end
    end

    // Reset values match the reset extents of one
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_DIMS; k++) begin
            if (!i_rst_n) begin
                r_prod[k] <= PB'(1);
                r_ovf[k]  <= 1'b0;
            end else begin
                r_prod[k] <= n_prod[k];
                r_ovf[k]  <= n_ovf[k];
            end
        end
    end

    assign o_size_err = r_ovf[MAX_DIMS-1];

    // Product never exceeds the index range; an overflowing stage keeps its input product
    a_prod_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prod[MAX_DIMS-1] <= LIMIT[PB-1:0])
        else $error("size product above index range");

endmodule

`default_nettype wire

>>> src/nart_back.sv
// Back end: destination index by Horner steps, one axis and one multiply per stage.
// Depends on nart_pkg; the last stage is the result register on the output side.
`default_nettype none

module nart_back import nart_pkg::*; #(
    parameter int MAX_DIMS    = MAX_DIMS_DEF,
    parameter int EXTENT_BITS = EXTENT_BITS_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] i_digits,
    input  wire logic [DATA_BITS-1:0]                 i_data,
    input  wire logic                                 i_last,
    input  wire logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] i_ext,
    input  wire logic [MAX_DIMS-1:0]                  i_use,
    input  wire logic                                 i_size_err,
    input  wire logic                                 i_pop,
    output logic                                      o_empty,
    output logic      [INDEX_BITS-1:0]                o_dest_index,
    output logic      [DATA_BITS-1:0]                 o_element_out,
    output logic                                      o_last,
    output logic                                      o_size_error
);

    localparam int L  = MAX_DIMS - 1;
    localparam int MB = INDEX_BITS + EXTENT_BITS;

    logic [MAX_DIMS-1:0]                  r_v;
    logic [INDEX_BITS-1:0]                r_acc  [MAX_DIMS];
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] r_dig  [MAX_DIMS];
    logic [DATA_BITS-1:0]                 r_data [MAX_DIMS];
    logic [MAX_DIMS-1:0]                  r_last;
    logic                                 r_serr;

    logic [MAX_DIMS:0]                    w_rdy;
    logic [MAX_DIMS-1:0]                  w_vin;
    logic [INDEX_BITS-1:0]                w_ain  [MAX_DIMS];
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] w_din  [MAX_DIMS];
    logic [DATA_BITS-1:0]                 w_xin  [MAX_DIMS];
    logic [MAX_DIMS-1:0]                  w_lin;
    logic [MB-1:0]                        w_sum  [MAX_DIMS];
    logic [INDEX_BITS-1:0]                n_acc  [MAX_DIMS];

    // Stage hand-off: a stage moves when it is empty or the next one moves
    always_comb begin
        w_rdy[MAX_DIMS] = i_pop;
        for (int j = L; j >= 0; j--) begin
            w_rdy[j] = !r_v[j] || w_rdy[j+1];
        end
    end
    assign o_ready = w_rdy[0];

    // Stage j handles axis MAX_DIMS-1-j: acc = acc * extent + digit
    always_comb begin
        for (int j = 0; j < MAX_DIMS; j++) begin
            if (j == 0) begin
                w_vin[j] = i_valid;
                w_ain[j] = '0;
                w_din[j] = i_digits;
                w_xin[j] = i_data;
                w_lin[j] = i_last;
            end else begin
                w_vin[j] = r_v[(j == 0) ? 0 : j - 1];
                w_ain[j] = r_acc[(j == 0) ? 0 : j - 1];
                w_din[j] = r_dig[(j == 0) ? 0 : j - 1];
                w_xin[j] = r_data[(j == 0) ? 0 : j - 1];
                w_lin[j] = r_last[(j == 0) ? 0 : j - 1];
            end
            w_sum[j] = ({{EXTENT_BITS{1'b0}}, w_ain[j]} * {{INDEX_BITS{1'b0}}, i_ext[L-j]})
                       + {{INDEX_BITS{1'b0}}, w_din[j][L-j]};
            n_acc[j] = i_use[L-j] ? w_sum[j][INDEX_BITS-1:0] : w_ain[j];
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int j = 0; j < MAX_DIMS; j++) begin
                if (w_rdy[j]) begin
                    r_v[j] <= w_vin[j];
                end
            end
        end
    end

    // Stage payload, no reset
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_DIMS; j++) begin
            if (w_rdy[j] && w_vin[j]) begin
                r_acc[j]  <= n_acc[j];
                r_dig[j]  <= w_din[j];
                r_data[j] <= w_xin[j];
                r_last[j] <= w_lin[j];
            end
        end
        if (w_rdy[L] && w_vin[L]) begin
            r_serr <= i_size_err;
        end
    end

    // Result side
    assign o_empty       = !r_v[L];
    assign o_dest_index  = r_acc[L];
    assign o_element_out = r_data[L];
    assign o_last        = r_last[L];
    assign o_size_error  = r_serr;

    // A full stage that cannot move keeps its request
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] && !w_rdy[1] |=> r_v[0] && $stable(r_acc[0]))
        else $error("first stage lost a request while stalled");

endmodule

`default_nettype wire

>>> src/nd_axis_reversal_transpose_top.sv
// Top level of the axis-reversal transpose address generator: config registers and wiring.
// Depends on nart_pkg, nart_front, nart_queue, nart_size and nart_back.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+--------------------------------------------
//  element  | in        | push / full            | i_element_bits
//  result   | out       | empty / pop            | o_dest_index, o_element_out, o_last,
//           |           |                        | o_size_error
//  config   | in        | valid / ready          | i_cfg_index, i_cfg_data
//
// One element per cycle sustained while full stays low; a result passes through the queue,
// then the multiply-add stages, the last being the result register, and can be popped
// once it sits on the output ports. Size error comes from an extent product pipeline of
// MAX_DIMS stages that settles after a register write; config ready is always high.
// Synchronous active-low reset clears the counter, queue and stage valid bits.
// A stalled result side fills the back stages, then the four-entry queue, then full rises.
`default_nettype none

module nd_axis_reversal_transpose_top import nart_pkg::*; #(
    parameter int MAX_DIMS    = MAX_DIMS_DEF,
    parameter int EXTENT_BITS = EXTENT_BITS_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // element requests
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic [DATA_BITS-1:0]                  i_element_bits,
    // results
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic      [INDEX_BITS-1:0]                 o_dest_index,
    output logic      [DATA_BITS-1:0]                  o_element_out,
    output logic                                       o_last,
    output logic                                       o_size_error,
    // configuration writes
    input  wire logic                                  valid,
    output logic                                       ready,
    input  wire logic [$clog2(MAX_DIMS+2)-1:0]         i_cfg_index,
    input  wire logic [EXTENT_BITS-1:0]                i_cfg_data
);

    localparam int IDX_BITS     = $clog2(MAX_DIMS + 2);
    localparam int NDIM_BITS    = $clog2(MAX_DIMS + 1);
    localparam int CfgIdxKind   = CFG_IDX_DIM_BASE + MAX_DIMS;
    localparam int ENTRY_BITS   = MAX_DIMS * EXTENT_BITS + DATA_BITS + 1;

    // Config held in normalised form: zero extents as one, dimension count as a mask
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] r_ext;
    logic [MAX_DIMS-1:0]                  r_use;
    logic                                 r_narrow;

    logic [NDIM_BITS-1:0]                 w_nd;
    logic [MAX_DIMS-1:0]                  w_use_new;
    logic                                 w_narrow_new;
    logic                                 w_wr;

    logic                                 w_accept;
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] w_fe_digits;
    logic [DATA_BITS-1:0]                 w_fe_data;
    logic                                 w_fe_last;
    logic [ENTRY_BITS-1:0]                w_q_wdata;
    logic [ENTRY_BITS-1:0]                w_q_rdata;
    logic                                 w_q_empty;
    logic                                 w_q_rd;
    logic                                 w_be_ready;
    logic                                 w_size_err;

    assign ready = 1'b1;
    assign w_wr  = valid & ready;

    // Dimension count clamped to 1..MAX_DIMS
    always_comb begin
        w_nd = i_cfg_data[NDIM_BITS-1:0];
        if (w_nd == '0) begin
            w_nd = NDIM_BITS'(1);
        end else if (w_nd > NDIM_BITS'(MAX_DIMS)) begin
            w_nd = NDIM_BITS'(MAX_DIMS);
        end
        for (int k = 0; k < MAX_DIMS; k++) begin
            w_use_new[k] = (NDIM_BITS'(k) < w_nd);
        end
    end

    // 32-bit kinds drop the upper word; unknown kind passes everything
    always_comb begin
        unique case (i_cfg_data[1:0]) inside
            KIND_INT32, KIND_FLOAT32: w_narrow_new = 1'b1;
            KIND_FLOAT64:             w_narrow_new = 1'b0;
            default:                  w_narrow_new = 1'b0;
        endcase
    end

    // Register writes; indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_DIMS; k++) begin
                r_ext[k] <= EXTENT_BITS'(1);
            end
            r_use    <= MAX_DIMS'(1);
            r_narrow <= 1'b0;
        end else if (w_wr) begin
            if (i_cfg_index == IDX_BITS'(CFG_IDX_NUM_DIMS)) begin
                r_use <= w_use_new;
            end else if (i_cfg_index == IDX_BITS'(CfgIdxKind)) begin
                r_narrow <= w_narrow_new;
            end else begin
                for (int k = 0; k < MAX_DIMS; k++) begin
                    if (i_cfg_index == IDX_BITS'(CFG_IDX_DIM_BASE + k)) begin
                        r_ext[k] <= (i_cfg_data == '0) ? EXTENT_BITS'(1) : i_cfg_data;
                    end
                end
            end
        end
    end

    // Front: classify and count
    assign w_accept = push & ~full;

    nart_front #(
        .MAX_DIMS    (MAX_DIMS),
        .EXTENT_BITS (EXTENT_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_element_bits (i_element_bits),
        .i_ext          (r_ext),
        .i_use          (r_use),
        .i_narrow       (r_narrow),
        .o_digits       (w_fe_digits),
        .o_data         (w_fe_data),
        .o_last         (w_fe_last)
    );

    // Queue between front and back
    assign w_q_wdata = {w_fe_digits, w_fe_data, w_fe_last};
    assign w_q_rd    = ~w_q_empty & w_be_ready;

    nart_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_accept),
        .i_wdata (w_q_wdata),
        .i_rd    (w_q_rd),
        .o_rdata (w_q_rdata),
        .o_full  (full),
        .o_empty (w_q_empty)
    );

    // Extent product check
    nart_size #(
        .MAX_DIMS    (MAX_DIMS),
        .EXTENT_BITS (EXTENT_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_size (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ext      (r_ext),
        .i_use      (r_use),
        .o_size_err (w_size_err)
    );

    // Back: destination index pipeline and result register
    nart_back #(
        .MAX_DIMS    (MAX_DIMS),
        .EXTENT_BITS (EXTENT_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (~w_q_empty),
        .o_ready       (w_be_ready),
        .i_digits      (w_q_rdata[ENTRY_BITS-1 -: MAX_DIMS*EXTENT_BITS]),
        .i_data        (w_q_rdata[DATA_BITS:1]),
        .i_last        (w_q_rdata[0]),
        .i_ext         (r_ext),
        .i_use         (r_use),
        .i_size_err    (w_size_err),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_dest_index  (o_dest_index),
        .o_element_out (o_element_out),
        .o_last        (o_last),
        .o_size_error  (o_size_error)
    );

endmodule

`default_nettype wire

>>> test/tb_nd_axis_reversal_transpose_top.sv
`timescale 1ns / 100ps
// Testbench for nd_axis_reversal_transpose_top: drives element and register requests, predicts
// each destination index, payload, last and size flag, and compares every result in order.
// Depends on nart_pkg and the block's RTL; needs no files or arguments.

module tb_nd_axis_reversal_transpose_top import nart_pkg::*;;

    localparam int MAX_DIMS     = MAX_DIMS_DEF;
    localparam int EXTENT_BITS  = EXTENT_BITS_DEF;
    localparam int INDEX_BITS   = INDEX_BITS_DEF;
    localparam int CFG_IDX_BITS = $clog2(MAX_DIMS + 2);

    // Register map past the extents
    localparam int REG_KIND  = CFG_IDX_DIM_BASE + MAX_DIMS;
    localparam int REG_SPARE = REG_KIND + 1;

    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam int LATENCY_PAD  = MAX_DIMS + 4;
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_ITEMS = 650;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic [INDEX_BITS-1:0] dest;
        logic [DATA_BITS-1:0]  elem;
        logic                  last;
        logic                  size_err;
    } t_transpose_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      push;
    logic                      full;
    logic [DATA_BITS-1:0]      i_element_bits;
    logic                      empty;
    logic                      pop;
    logic [INDEX_BITS-1:0]     o_dest_index;
    logic [DATA_BITS-1:0]      o_element_out;
    logic                      o_last;
    logic                      o_size_error;
    logic                      valid;
    logic                      ready;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index;
    logic [EXTENT_BITS-1:0]    i_cfg_data;

    // Register shadow and counter state of the predictor
    logic [2:0]                reg_num_dims;
    logic [EXTENT_BITS-1:0]    reg_extent [MAX_DIMS];
    logic [1:0]                reg_kind;
    logic [EXTENT_BITS-1:0]    src_digit [MAX_DIMS];
    logic [INDEX_BITS-1:0]     last_dest;

    t_transpose_result         pending_results [$];
    int                        error_count = 0;
    logic                      tx_idle_on = 1'b0;
    logic                      rx_idle_on = 1'b0;
    logic                      hold_req = 1'b0;

    nd_axis_reversal_transpose_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_element_bits (i_element_bits),
        .empty          (empty),
        .pop            (pop),
        .o_dest_index   (o_dest_index),
        .o_element_out  (o_element_out),
        .o_last         (o_last),
        .o_size_error   (o_size_error),
        .valid          (valid),
        .ready          (ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic int dims_active();
        int n;
        n = int'(reg_num_dims);
        if (n == 0) n = 1;
        if (n > MAX_DIMS) n = MAX_DIMS;
        return n;
    endfunction

    // zero extent behaves as one
    function automatic logic [63:0] axis_extent(int k);
        logic [63:0] e;
        e = 64'(reg_extent[k]);
        if (e == 64'd0) e = 64'd1;
        return e;
    endfunction

    function automatic logic [63:0] array_span();
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < dims_active(); k++) p = p * axis_extent(k);
        return p;
    endfunction

    // Index from the current digits, then advance the counter (last axis fastest)
    function automatic t_transpose_result transpose_step(logic [DATA_BITS-1:0] bits);
        int                    n;
        logic [INDEX_BITS-1:0] acc;
        logic [EXTENT_BITS:0]  nxt;
        logic                  carry;
        t_transpose_result     r;
        n = dims_active();
        acc = INDEX_BITS'(src_digit[n-1]);
        for (int k = n - 2; k >= 0; k--)
            acc = INDEX_BITS'(acc * axis_extent(k) + 64'(src_digit[k]));
        last_dest = acc;
        carry = 1'b1;
        for (int k = n - 1; k >= 0 && carry; k--) begin
            nxt = {1'b0, src_digit[k]} + (EXTENT_BITS+1)'(1);
            // a stale digit at or past its extent wraps like the top digit
            if (64'(nxt) >= axis_extent(k)) begin
                src_digit[k] = '0;
            end else begin
                src_digit[k] = nxt[EXTENT_BITS-1:0];
                carry = 1'b0;
            end
        end
        r.dest = last_dest;
        if (reg_kind == KIND_INT32 || reg_kind == KIND_FLOAT32) begin
            r.elem = {{(DATA_BITS-NARROW_BITS){1'b0}}, bits[NARROW_BITS-1:0]};
        end else begin
            r.elem = bits;
        end
        r.last = carry;
        r.size_err = array_span() > (64'd1 << INDEX_BITS);
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    // mostly short gaps, a few long
    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 55) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    function automatic logic [DATA_BITS-1:0] random_bits();
        int r;
        r = int'($urandom_range(0, 9));
        if (r == 0) return '1;
        if (r == 1) return '0;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [EXTENT_BITS-1:0] pick_extent();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 80) return EXTENT_BITS'($urandom_range(1, 4));
        if (r < 87) return EXTENT_BITS'($urandom_range(5, 9));
        if (r < 92) return '0;
        if (r < 96) return '1;
        return EXTENT_BITS'($urandom);
    endfunction

    // One element request; the prediction is taken at the accepting edge
    task automatic send_element(input logic [DATA_BITS-1:0] bits);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge i_clk) push <= 1'b0;
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_element_bits <= bits;
        do @(posedge i_clk); while (full);
        pending_results.push_back(transpose_step(bits));
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [EXTENT_BITS-1:0] data);
        @(negedge i_clk);
        valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!ready);
        if (idx == CFG_IDX_NUM_DIMS) begin
            reg_num_dims = data[2:0];
        end else if (idx >= CFG_IDX_DIM_BASE && idx < CFG_IDX_DIM_BASE + MAX_DIMS) begin
            reg_extent[idx - CFG_IDX_DIM_BASE] = data;
        end else if (idx == REG_KIND) begin
            reg_kind = data[1:0];
        end
        // indexes past the list are dropped
        @(negedge i_clk) valid <= 1'b0;
    endtask

    // Stop sending and let every outstanding result come out
    task automatic wait_drained();
        @(negedge i_clk) push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    task automatic configure(input logic [EXTENT_BITS-1:0] dims_word,
                             input logic [EXTENT_BITS-1:0] e0, e1, e2, e3,
                             input logic [EXTENT_BITS-1:0] kind_word);
        wait_drained();
        write_reg(CFG_IDX_BITS'(CFG_IDX_NUM_DIMS), dims_word);
        write_reg(CFG_IDX_BITS'(CFG_IDX_DIM_BASE), e0);
        write_reg(CFG_IDX_BITS'(CFG_IDX_DIM_BASE + 1), e1);
        write_reg(CFG_IDX_BITS'(CFG_IDX_DIM_BASE + 2), e2);
        write_reg(CFG_IDX_BITS'(CFG_IDX_DIM_BASE + 3), e3);
        write_reg(CFG_IDX_BITS'(REG_KIND), kind_word);
        // size flag pipeline settles
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    // ---------------- result side ----------------

    initial begin : result_sink
        int   stall_left;
        int   hold_left;
        logic take;
        stall_left = 0;
        hold_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                take = 1'b0;
            end else begin
                take = 1'b1;
                if (rx_idle_on) stall_left = pick_gap();
            end
            pop <= take;
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Compare each popped result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_transpose_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, got dest %h elem %h",
                         $time, o_dest_index, o_element_out);
            end else begin
                want = pending_results.pop_front();
                check_field("dest_index", 64'(want.dest), 64'(o_dest_index));
                check_field("element_out", want.elem, o_element_out);
                check_field("last", 64'(want.last), 64'(o_last));
                check_field("size_error", 64'(want.size_err), 64'(o_size_error));
            end
        end
    end

    // ---------------- tests ----------------

    // Reset values: one axis of extent one, full-width payload
    task automatic test_reset_state();
        send_element('1);
        send_element(64'h8000_0000_0000_0001);
    endtask

    task automatic test_element_kinds();
        logic [1:0] kinds [4];
        kinds = '{KIND_INT32, KIND_FLOAT32, KIND_FLOAT64, KIND_UNKNOWN};
        foreach (kinds[i]) begin
            configure(16'd2, 16'd2, 16'd3, 16'd1, 16'd1, {14'd0, kinds[i]});
            send_element('1);
            send_element(64'hA5A5_5A5A_0F0F_F0F0);
        end
    endtask

    // Zero and out-of-range dimension counts, zero extents
    task automatic test_dimension_corners();
        configure(16'd0, 16'd2, 16'd3, 16'd3, 16'd3, {14'd0, KIND_FLOAT64});
        send_element(random_bits());
        send_element(random_bits());
        configure(16'hFFFF, 16'd0, 16'd1, 16'd0, 16'd2, {14'd0, KIND_INT32});
        send_element(random_bits());
        send_element(random_bits());
    endtask

    // Extent products over, and exactly at, the index range
    task automatic test_size_overflow();
        configure(16'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, {14'd0, KIND_FLOAT64});
        send_element(random_bits());
        send_element(random_bits());
        configure(16'd4, 16'd256, 16'd256, 16'd256, 16'd256, {14'd0, KIND_FLOAT32});
        send_element(random_bits());
        configure(16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, {14'd0, KIND_FLOAT64});
        send_element(random_bits());
    endtask

    // Shrink an extent mid-array so the counter sits beyond it
    task automatic test_stale_counter();
        configure(16'd1, 16'd5, 16'd1, 16'd1, 16'd1, {14'd0, KIND_FLOAT64});
        repeat (3) send_element(random_bits());
        wait_drained();
        write_reg(CFG_IDX_BITS'(CFG_IDX_DIM_BASE), 16'd2);
        repeat (LATENCY_PAD) @(posedge i_clk);
        send_element(random_bits());
    endtask

    task automatic test_spare_register();
        wait_drained();
        write_reg(CFG_IDX_BITS'(REG_SPARE), 16'hFFFF);
        write_reg(CFG_IDX_BITS'(REG_SPARE + 1), 16'h0003);
        repeat (LATENCY_PAD) @(posedge i_clk);
        send_element(random_bits());
    endtask

    // Random settings, mostly small arrays run through whole
    task automatic test_random_arrays();
        int                     sent;
        int                     burst;
        logic [63:0]            span;
        logic [EXTENT_BITS-1:0] dims_word;
        dims_word = '0;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            dims_word = EXTENT_BITS'($urandom);
            dims_word[2:0] = 3'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                           : $urandom_range(5, 8) % 8);
            configure(dims_word, pick_extent(), pick_extent(), pick_extent(),
                      pick_extent(), EXTENT_BITS'($urandom));
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_IDX_BITS'(REG_SPARE + $urandom_range(0, 1)),
                          EXTENT_BITS'($urandom));
            span = array_span();
            if (span <= 64'd48) burst = int'(span) + int'($urandom_range(0, int'(span)));
            else burst = int'($urandom_range(10, 48));
            repeat (burst) send_element(random_bits());
            sent += burst;
        end
    endtask

    // Receiver holds off while the sender keeps offering, then a full drain
    task automatic test_full_backpressure();
        configure(16'd2, 16'd3, 16'd4, 16'd1, 16'd1, {14'd0, KIND_FLOAT32});
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_element(random_bits());
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        valid = 1'b0;
        i_element_bits = '0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        reg_num_dims = 3'd1;
        reg_kind = KIND_FLOAT64;
        last_dest = '0;
        foreach (reg_extent[k]) begin
            reg_extent[k] = EXTENT_BITS'(1);
            src_digit[k] = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_reset_state();
        test_element_kinds();
        test_dimension_corners();
        test_size_overflow();
        test_stale_counter();
        test_spare_register();
        test_full_backpressure();
        test_random_arrays();

        wait_drained();
        repeat (2 * LATENCY_PAD) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
